### rtl/tcs_pkg.sv
// tcs_pkg: shared types and constants for the circumsphere inside-test unit.
// No dependencies; imported by tcs_out_if and every module.

package tcs_pkg;

    // Two-bit signed sign code: +1, 0, -1.
    typedef logic signed [1:0] sign_t;

    localparam sign_t SIGN_POS  = 2'sb01;
    localparam sign_t SIGN_ZERO = 2'sb00;
    localparam sign_t SIGN_NEG  = 2'sb11;

    // Configuration register indexes.
    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_QUERY_X = 2'd0;
    localparam cfg_idx_t CFG_QUERY_Y = 2'd1;
    localparam cfg_idx_t CFG_QUERY_Z = 2'd2;

    function automatic sign_t sign_of(input logic is_neg, input logic is_zero);
        sign_t s;
        if (is_neg)
        begin
            s = SIGN_NEG;
        end
        else if (is_zero)
        begin
            s = SIGN_ZERO;
        end
        else
        begin
            s = SIGN_POS;
        end
        return s;
    endfunction

endpackage

### rtl/tcs_if.sv
// tcs_if: request and result channel interfaces (valid/ready plus payload).
// Depends on tcs_pkg for the sign code type.

interface tcs_in_if #(parameter int CB = 16);
    logic valid;
    logic ready;
    logic signed [CB-1:0] va_x, va_y, va_z;
    logic signed [CB-1:0] vb_x, vb_y, vb_z;
    logic signed [CB-1:0] vc_x, vc_y, vc_z;
    logic signed [CB-1:0] vd_x, vd_y, vd_z;

    modport source (output valid, va_x, va_y, va_z, vb_x, vb_y, vb_z,
                    vc_x, vc_y, vc_z, vd_x, vd_y, vd_z, input ready);
    modport sink (input valid, va_x, va_y, va_z, vb_x, vb_y, vb_z,
                  vc_x, vc_y, vc_z, vd_x, vd_y, vd_z, output ready);
endinterface

interface tcs_out_if import tcs_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  inside_res;
    sign_t orient_sign;
    sign_t sphere_sign;

    modport source (output valid, inside_res, orient_sign, sphere_sign, input ready);
    modport sink (input valid, inside_res, orient_sign, sphere_sign, output ready);
endinterface

### rtl/tet_circumsphere_inside_test_unit.sv
// tet_circumsphere_inside_test_unit: orient3d / insphere sign test, exact integer.
// Depends on tcs_pkg, tcs_if (tcs_in_if, tcs_out_if) and tcs_det3.
//
//  port     | dir  | carries
//  ---------+------+---------------------------------------------------
//  in_ch    | sink | request: vertices a, b, c, d (x, y, z each)
//  res      | src  | inside_res, orient_sign, sphere_sign
//  cfg_*    | in   | write-only query point registers x, y, z
//
// Throughput one request per cycle while the output is not stalled.
// A request passes through the difference stage, the det3 pipeline (4 stages), the
// split lift x det multiply, term assembly, two-level sum and the output register.
// The whole pipeline advances when the output stage is empty or taken; a stall
// freezes every stage, so nothing is dropped or repeated.
// rst_n clears valid bits and query registers; data registers are not reset.

module tet_circumsphere_inside_test_unit import tcs_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcs_in_if.sink                in_ch,
    tcs_out_if.source             res,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [COORD_BITS-1:0] cfg_wdata
);

    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;          // coordinate difference
    localparam int SQW  = 2 * D;          // square of a difference
    localparam int LW   = 2 * D + 2;      // lifted coordinate (sum of squares)
    localparam int DW   = 3 * D + 3;      // 3x3 determinant
    localparam int H    = (DW + 1) / 2;   // low half of a determinant
    localparam int HW   = DW - H;         // high half (signed)
    localparam int PLW  = LW + H + 1;
    localparam int PHW  = LW + HW;
    localparam int TW   = LW + DW;        // one insphere cofactor term
    localparam int SW   = TW + 2;         // insphere determinant
    localparam int NSTG = 10;

    // Query point registers
    logic signed [C-1:0] qx_reg, qy_reg, qz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_QUERY_X)
            begin
                qx_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_QUERY_Y)
            begin
                qy_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_QUERY_Z)
            begin
                qz_reg <= cfg_wdata;
            end
        end
    end

    // Pipeline control: one global advance
    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv         = !vld_reg[NSTG-1] || res.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_ch.valid};
        end
    end

    // Stage 1: differences
    logic signed [C-1:0] vin [4][3];
    logic signed [C-1:0] qv  [3];
    logic signed [D-1:0] od_reg [3][3];
    logic signed [D-1:0] sd_reg [4][3];

    always_comb
    begin
        vin[0][0] = in_ch.va_x; vin[0][1] = in_ch.va_y; vin[0][2] = in_ch.va_z;
        vin[1][0] = in_ch.vb_x; vin[1][1] = in_ch.vb_y; vin[1][2] = in_ch.vb_z;
        vin[2][0] = in_ch.vc_x; vin[2][1] = in_ch.vc_y; vin[2][2] = in_ch.vc_z;
        vin[3][0] = in_ch.vd_x; vin[3][1] = in_ch.vd_y; vin[3][2] = in_ch.vd_z;
        qv[0] = qx_reg;
        qv[1] = qy_reg;
        qv[2] = qz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sd_reg[i][k] <= D'(vin[i][k]) - D'(qv[k]);
                    if (i < 3)
                    begin
                        od_reg[i][k] <= D'(vin[i][k]) - D'(vin[3][k]);
                    end
                end
            end
        end
    end

    // Stages 2-5: determinants
    logic signed [DW-1:0] det_o;
    logic signed [DW-1:0] det_s [4];   // det_s[j]: rows other than j

    tcs_det3 #(.W(D)) u_det_o (
        .clk (clk),
        .en  (adv),
        .p   (od_reg[0]),
        .q   (od_reg[1]),
        .r   (od_reg[2]),
        .det (det_o)
    );

    for (genvar j = 0; j < 4; j++)
    begin : g_sph
        localparam int R0 = (j == 0) ? 1 : 0;
        localparam int R1 = (j <= 1) ? 2 : 1;
        localparam int R2 = (j <= 2) ? 3 : 2;

        tcs_det3 #(.W(D)) u_det_s (
            .clk (clk),
            .en  (adv),
            .p   (sd_reg[R0]),
            .q   (sd_reg[R1]),
            .r   (sd_reg[R2]),
            .det (det_s[j])
        );
    end

    // Lift (squared distance to query) alongside: square, sum, two delays
    logic signed [SQW-1:0] sq_reg [4][3];
    logic signed [LW-1:0]  lf3_reg [4];
    logic signed [LW-1:0]  lf4_reg [4];
    logic signed [LW-1:0]  lf5_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sq_reg[i][k] <= SQW'(sd_reg[i][k]) * SQW'(sd_reg[i][k]);
                end
                lf3_reg[i] <= LW'(sq_reg[i][0]) + LW'(sq_reg[i][1]) + LW'(sq_reg[i][2]);
            end
            lf4_reg <= lf3_reg;
            lf5_reg <= lf4_reg;
        end
    end

    // Stage 6: lift x det split in two partial products; orient sign
    // Stage 7: assemble terms; stage 8: pair sums; stage 9: total
    logic signed [PLW-1:0] pl_reg [4];
    logic signed [PHW-1:0] ph_reg [4];
    logic signed [TW-1:0]  trm_reg [4];
    logic signed [SW-1:0]  pa_reg, pb_reg, tot_reg;
    sign_t                 os6_reg, os7_reg, os8_reg, os9_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pl_reg[j] <= PLW'(lf5_reg[j]) * PLW'($signed({1'b0, det_s[j][H-1:0]}));
                ph_reg[j] <= PHW'(lf5_reg[j]) * PHW'($signed(det_s[j][DW-1:H]));
                trm_reg[j] <= (TW'(ph_reg[j]) <<< H) + TW'(pl_reg[j]);
            end
            os6_reg <= sign_of(det_o[DW-1], det_o == '0);
            os7_reg <= os6_reg;
            os8_reg <= os7_reg;
            // + L3*D012 - L2*D013 + L1*D023 - L0*D123
            pa_reg  <= SW'(trm_reg[3]) - SW'(trm_reg[2]);
            pb_reg  <= SW'(trm_reg[1]) - SW'(trm_reg[0]);
            os9_reg <= os8_reg;
            tot_reg <= pa_reg + pb_reg;
        end
    end

    // Stage 10: output register
    logic  ins_reg;
    sign_t osg_reg, ssg_reg;
    sign_t ss9;

    assign ss9 = sign_of(tot_reg[SW-1], tot_reg == '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            osg_reg <= os9_reg;
            ssg_reg <= ss9;
            ins_reg <= (os9_reg != SIGN_ZERO) && (os9_reg == ss9);
        end
    end

    assign res.valid       = vld_reg[NSTG-1];
    assign res.inside_res  = ins_reg;
    assign res.orient_sign = osg_reg;
    assign res.sphere_sign = ssg_reg;

`ifndef SYNTHESIS
    a_inside_same_sign: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.inside_res |->
            res.orient_sign == res.sphere_sign && res.orient_sign != SIGN_ZERO)
        else $error("inside set with mismatched or zero signs");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_sign_codes: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.orient_sign != 2'sb10 && res.sphere_sign != 2'sb10)
        else $error("illegal sign code at result");
`endif

endmodule

### rtl/tcs_det3.sv
// tcs_det3: four-stage pipelined exact 3x3 determinant of rows p, q, r.
// Depends on tcs_pkg; all stages advance together on en.

module tcs_det3 import tcs_pkg::*; #(
    parameter int W = 17
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [W-1:0]    p [3],
    input  logic signed [W-1:0]    q [3],
    input  logic signed [W-1:0]    r [3],
    output logic signed [3*W+2:0]  det
);

    localparam int PW = 2 * W;      // pair product
    localparam int MW = 2 * W + 1;  // 2x2 minor
    localparam int TW = 3 * W + 1;  // row element times minor
    localparam int DW = 3 * W + 3;  // determinant

    logic signed [PW-1:0] prd_reg [6];
    logic signed [W-1:0]  pa_reg [3];
    logic signed [W-1:0]  pb_reg [3];
    logic signed [MW-1:0] min_reg [3];
    logic signed [TW-1:0] trm_reg [3];
    logic signed [DW-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products of the 2x2 minors
            prd_reg[0] <= PW'(q[1]) * PW'(r[2]);
            prd_reg[1] <= PW'(q[2]) * PW'(r[1]);
            prd_reg[2] <= PW'(q[0]) * PW'(r[2]);
            prd_reg[3] <= PW'(q[2]) * PW'(r[0]);
            prd_reg[4] <= PW'(q[0]) * PW'(r[1]);
            prd_reg[5] <= PW'(q[1]) * PW'(r[0]);
            pa_reg     <= p;
            // minors
            min_reg[0] <= MW'(prd_reg[0]) - MW'(prd_reg[1]);
            min_reg[1] <= MW'(prd_reg[2]) - MW'(prd_reg[3]);
            min_reg[2] <= MW'(prd_reg[4]) - MW'(prd_reg[5]);
            pb_reg     <= pa_reg;
            // cofactor terms
            for (int i = 0; i < 3; i++)
            begin
                trm_reg[i] <= TW'(pb_reg[i]) * TW'(min_reg[i]);
            end
            det_reg <= DW'(trm_reg[0]) - DW'(trm_reg[1]) + DW'(trm_reg[2]);
        end
    end

    assign det = det_reg;

endmodule
